// ----- rtl/cpu8_register_alu_execute_unit_defines.svh -----
// Assertion macros shared by the execute unit RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CPU8_REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH
`define CPU8_REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH

// Checked on every rising edge, switched off while reset is held.
`define CPU8_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, including reset cycles.
`define CPU8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cpu8_pkg.sv -----
// Types, operation codes and flag helpers for the 8-bit execute unit.
// No dependencies; used by every module of the block.
package cpu8_pkg;

  typedef struct packed {
    logic [5:0] command;
    logic [7:0] operand;
    logic       on_accumulator;
  } in_item_t;

  typedef struct packed {
    logic [7:0] write_data;
    logic       write_enable;
    logic       push_enable;
    logic [8:0] stack_address;
    logic       branch_taken;
    logic [7:0] status_out;
    logic [7:0] accumulator_out;
    logic [7:0] index_x_out;
    logic [7:0] index_y_out;
  } out_item_t;

  // Programmer-visible registers.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic [7:0] sp;
  } arch_t;

  // Handshake between the execute logic and the register file.
  typedef struct packed {
    logic  commit;
    arch_t arch;
  } arch_upd_t;

  localparam logic [7:0] SP_RESET  = 8'hFD;
  localparam logic [7:0] PUSH_BITS = 8'h30;
  localparam logic [7:0] ONE_BIT   = 8'h20;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [5:0] CMD_ADC = 6'd0;
  localparam logic [5:0] CMD_AND = 6'd1;
  localparam logic [5:0] CMD_ASL = 6'd2;
  localparam logic [5:0] CMD_BCC = 6'd3;
  localparam logic [5:0] CMD_BCS = 6'd4;
  localparam logic [5:0] CMD_BEQ = 6'd5;
  localparam logic [5:0] CMD_BIT = 6'd6;
  localparam logic [5:0] CMD_BMI = 6'd7;
  localparam logic [5:0] CMD_BNE = 6'd8;
  localparam logic [5:0] CMD_BPL = 6'd9;
  localparam logic [5:0] CMD_BRK = 6'd10;
  localparam logic [5:0] CMD_BVC = 6'd11;
  localparam logic [5:0] CMD_BVS = 6'd12;
  localparam logic [5:0] CMD_CLC = 6'd13;
  localparam logic [5:0] CMD_CLD = 6'd14;
  localparam logic [5:0] CMD_CLI = 6'd15;
  localparam logic [5:0] CMD_CLV = 6'd16;
  localparam logic [5:0] CMD_CMP = 6'd17;
  localparam logic [5:0] CMD_CPX = 6'd18;
  localparam logic [5:0] CMD_CPY = 6'd19;
  localparam logic [5:0] CMD_DEC = 6'd20;
  localparam logic [5:0] CMD_DEX = 6'd21;
  localparam logic [5:0] CMD_DEY = 6'd22;
  localparam logic [5:0] CMD_EOR = 6'd23;
  localparam logic [5:0] CMD_INC = 6'd24;
  localparam logic [5:0] CMD_INX = 6'd25;
  localparam logic [5:0] CMD_INY = 6'd26;
  localparam logic [5:0] CMD_LDA = 6'd29;
  localparam logic [5:0] CMD_LDX = 6'd30;
  localparam logic [5:0] CMD_LDY = 6'd31;
  localparam logic [5:0] CMD_LSR = 6'd32;
  localparam logic [5:0] CMD_ORA = 6'd34;
  localparam logic [5:0] CMD_PHA = 6'd35;
  localparam logic [5:0] CMD_PHP = 6'd36;
  localparam logic [5:0] CMD_PLA = 6'd37;
  localparam logic [5:0] CMD_PLP = 6'd38;
  localparam logic [5:0] CMD_ROL = 6'd39;
  localparam logic [5:0] CMD_ROR = 6'd40;
  localparam logic [5:0] CMD_SBC = 6'd43;
  localparam logic [5:0] CMD_SEC = 6'd44;
  localparam logic [5:0] CMD_SED = 6'd45;
  localparam logic [5:0] CMD_SEI = 6'd46;
  localparam logic [5:0] CMD_STA = 6'd47;
  localparam logic [5:0] CMD_STX = 6'd48;
  localparam logic [5:0] CMD_STY = 6'd49;
  localparam logic [5:0] CMD_TAX = 6'd50;
  localparam logic [5:0] CMD_TAY = 6'd51;
  localparam logic [5:0] CMD_TSX = 6'd52;
  localparam logic [5:0] CMD_TXA = 6'd53;
  localparam logic [5:0] CMD_TXS = 6'd54;
  localparam logic [5:0] CMD_TYA = 6'd55;

  // Updates N and Z from a result byte, leaving the other flags alone.
  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r         = p;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

endpackage

// ----- rtl/cpu8_exec.sv -----
// Combinational execute logic: one decoded operation against the current registers.
// Depends on cpu8_pkg for the item, register and operation code definitions.
module cpu8_exec (
  input  cpu8_pkg::in_item_t  item,
  input  cpu8_pkg::arch_t     cur,
  output cpu8_pkg::arch_t     nxt,
  output cpu8_pkg::out_item_t result
);

  logic [7:0] m;
  logic [7:0] add_op;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] src;
  logic [7:0] sh_res;
  logic       sh_c;
  logic [7:0] wdata;
  logic       we;
  logic       push;
  logic       br;

  assign m = item.operand;

  // SBC is ADC of the inverted operand; the carry acts as the borrow complement.
  assign add_op = (item.command == cpu8_pkg::CMD_SBC) ? ~m : m;
  assign sum    = {1'b0, cur.a} + {1'b0, add_op} + {8'd0, cur.p[cpu8_pkg::FLAG_C]};

  always_comb begin
    case (item.command)
      cpu8_pkg::CMD_CPX: cmp_reg = cur.x;
      cpu8_pkg::CMD_CPY: cmp_reg = cur.y;
      default:           cmp_reg = cur.a;
    endcase
  end

  assign diff = {1'b0, cmp_reg} - {1'b0, m};
  assign src  = item.on_accumulator ? cur.a : m;

  always_comb begin
    case (item.command)
      cpu8_pkg::CMD_ASL: begin
        sh_res = {src[6:0], 1'b0};
        sh_c   = src[7];
      end
      cpu8_pkg::CMD_ROL: begin
        sh_res = {src[6:0], cur.p[cpu8_pkg::FLAG_C]};
        sh_c   = src[7];
      end
      cpu8_pkg::CMD_ROR: begin
        sh_res = {cur.p[cpu8_pkg::FLAG_C], src[7:1]};
        sh_c   = src[0];
      end
      default: begin
        sh_res = {1'b0, src[7:1]};
        sh_c   = src[0];
      end
    endcase
  end

  always_comb begin
    nxt   = cur;
    wdata = 8'h00;
    we    = 1'b0;
    push  = 1'b0;
    br    = 1'b0;
    case (item.command)
      cpu8_pkg::CMD_ADC, cpu8_pkg::CMD_SBC: begin
        nxt.a                   = sum[7:0];
        nxt.p                   = cpu8_pkg::set_nz(cur.p, sum[7:0]);
        nxt.p[cpu8_pkg::FLAG_C] = sum[8];
        nxt.p[cpu8_pkg::FLAG_V] = ~(cur.a[7] ^ add_op[7]) & (cur.a[7] ^ sum[7]);
      end
      cpu8_pkg::CMD_AND: begin
        nxt.a = cur.a & m;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.a & m);
      end
      cpu8_pkg::CMD_EOR: begin
        nxt.a = cur.a ^ m;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.a ^ m);
      end
      cpu8_pkg::CMD_ORA: begin
        nxt.a = cur.a | m;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.a | m);
      end
      cpu8_pkg::CMD_ASL, cpu8_pkg::CMD_LSR, cpu8_pkg::CMD_ROL, cpu8_pkg::CMD_ROR: begin
        nxt.p                   = cpu8_pkg::set_nz(cur.p, sh_res);
        nxt.p[cpu8_pkg::FLAG_C] = sh_c;
        if (item.on_accumulator) begin
          nxt.a = sh_res;
        end else begin
          wdata = sh_res;
          we    = 1'b1;
        end
      end
      cpu8_pkg::CMD_BCC: br = ~cur.p[cpu8_pkg::FLAG_C];
      cpu8_pkg::CMD_BCS: br = cur.p[cpu8_pkg::FLAG_C];
      cpu8_pkg::CMD_BEQ: br = cur.p[cpu8_pkg::FLAG_Z];
      cpu8_pkg::CMD_BMI: br = cur.p[cpu8_pkg::FLAG_N];
      cpu8_pkg::CMD_BNE: br = ~cur.p[cpu8_pkg::FLAG_Z];
      cpu8_pkg::CMD_BPL: br = ~cur.p[cpu8_pkg::FLAG_N];
      cpu8_pkg::CMD_BVC: br = ~cur.p[cpu8_pkg::FLAG_V];
      cpu8_pkg::CMD_BVS: br = cur.p[cpu8_pkg::FLAG_V];
      cpu8_pkg::CMD_BIT: begin
        nxt.p[cpu8_pkg::FLAG_Z] = ((cur.a & m) == 8'h00);
        nxt.p[cpu8_pkg::FLAG_V] = m[6];
        nxt.p[cpu8_pkg::FLAG_N] = m[7];
      end
      cpu8_pkg::CMD_BRK, cpu8_pkg::CMD_PHP: begin
        wdata  = cur.p | cpu8_pkg::PUSH_BITS;
        push   = 1'b1;
        nxt.sp = cur.sp - 8'd1;
        if (item.command == cpu8_pkg::CMD_BRK) begin
          nxt.p[cpu8_pkg::FLAG_I] = 1'b1;
        end
      end
      cpu8_pkg::CMD_PHA: begin
        wdata  = cur.a;
        push   = 1'b1;
        nxt.sp = cur.sp - 8'd1;
      end
      cpu8_pkg::CMD_PLA: begin
        nxt.sp = cur.sp + 8'd1;
        nxt.a  = m;
        nxt.p  = cpu8_pkg::set_nz(cur.p, m);
      end
      cpu8_pkg::CMD_PLP: begin
        nxt.sp = cur.sp + 8'd1;
        nxt.p  = m & ~cpu8_pkg::PUSH_BITS;
      end
      cpu8_pkg::CMD_CLC: nxt.p[cpu8_pkg::FLAG_C] = 1'b0;
      cpu8_pkg::CMD_CLD: nxt.p[cpu8_pkg::FLAG_D] = 1'b0;
      cpu8_pkg::CMD_CLI: nxt.p[cpu8_pkg::FLAG_I] = 1'b0;
      cpu8_pkg::CMD_CLV: nxt.p[cpu8_pkg::FLAG_V] = 1'b0;
      cpu8_pkg::CMD_SEC: nxt.p[cpu8_pkg::FLAG_C] = 1'b1;
      cpu8_pkg::CMD_SED: nxt.p[cpu8_pkg::FLAG_D] = 1'b1;
      cpu8_pkg::CMD_SEI: nxt.p[cpu8_pkg::FLAG_I] = 1'b1;
      cpu8_pkg::CMD_CMP, cpu8_pkg::CMD_CPX, cpu8_pkg::CMD_CPY: begin
        nxt.p[cpu8_pkg::FLAG_C] = ~diff[8];
        nxt.p[cpu8_pkg::FLAG_Z] = (cmp_reg == m);
        nxt.p[cpu8_pkg::FLAG_N] = diff[7];
      end
      cpu8_pkg::CMD_DEC: begin
        wdata = m - 8'd1;
        we    = 1'b1;
        nxt.p = cpu8_pkg::set_nz(cur.p, m - 8'd1);
      end
      cpu8_pkg::CMD_INC: begin
        wdata = m + 8'd1;
        we    = 1'b1;
        nxt.p = cpu8_pkg::set_nz(cur.p, m + 8'd1);
      end
      cpu8_pkg::CMD_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.x - 8'd1);
      end
      cpu8_pkg::CMD_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.y - 8'd1);
      end
      cpu8_pkg::CMD_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.x + 8'd1);
      end
      cpu8_pkg::CMD_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.y + 8'd1);
      end
      cpu8_pkg::CMD_LDA: begin
        nxt.a = m;
        nxt.p = cpu8_pkg::set_nz(cur.p, m);
      end
      cpu8_pkg::CMD_LDX: begin
        nxt.x = m;
        nxt.p = cpu8_pkg::set_nz(cur.p, m);
      end
      cpu8_pkg::CMD_LDY: begin
        nxt.y = m;
        nxt.p = cpu8_pkg::set_nz(cur.p, m);
      end
      cpu8_pkg::CMD_STA: begin
        wdata = cur.a;
        we    = 1'b1;
      end
      cpu8_pkg::CMD_STX: begin
        wdata = cur.x;
        we    = 1'b1;
      end
      cpu8_pkg::CMD_STY: begin
        wdata = cur.y;
        we    = 1'b1;
      end
      cpu8_pkg::CMD_TAX: begin
        nxt.x = cur.a;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.a);
      end
      cpu8_pkg::CMD_TAY: begin
        nxt.y = cur.a;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.a);
      end
      cpu8_pkg::CMD_TSX: begin
        nxt.x = cur.sp;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.sp);
      end
      cpu8_pkg::CMD_TXA: begin
        nxt.a = cur.x;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.x);
      end
      cpu8_pkg::CMD_TXS: nxt.sp = cur.x;
      cpu8_pkg::CMD_TYA: begin
        nxt.a = cur.y;
        nxt.p = cpu8_pkg::set_nz(cur.p, cur.y);
      end
      default: ;
    endcase
  end

  // A push reports the slot it writes; everything else reports the pointer after the step.
  always_comb begin
    result.write_data      = wdata;
    result.write_enable    = we;
    result.push_enable     = push;
    result.stack_address   = {1'b1, (push ? cur.sp : nxt.sp)};
    result.branch_taken    = br;
    result.status_out      = nxt.p | cpu8_pkg::ONE_BIT;
    result.accumulator_out = nxt.a;
    result.index_x_out     = nxt.x;
    result.index_y_out     = nxt.y;
  end

endmodule

// ----- rtl/cpu8_state.sv -----
// Architectural register file: A, X, Y, status and stack pointer.
// Depends on cpu8_pkg; updated once per committed operation.
module cpu8_state (
  input  logic                clk,
  input  logic                rst_n,
  input  cpu8_pkg::arch_upd_t upd,
  output cpu8_pkg::arch_t     arch
);

  cpu8_pkg::arch_t arch_r;
  cpu8_pkg::arch_t arch_nxt;

  assign arch_nxt = upd.commit ? upd.arch : arch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r.a  <= 8'h00;
      arch_r.x  <= 8'h00;
      arch_r.y  <= 8'h00;
      arch_r.p  <= 8'h00;
      arch_r.sp <= cpu8_pkg::SP_RESET;
    end else begin
      arch_r <= arch_nxt;
    end
  end

  assign arch = arch_r;

endmodule

// ----- rtl/cpu8_register_alu_execute_unit.sv -----
// Each accepted operation passes through the input register and then the result register.
// Throughput: one operation per cycle while the result side keeps up.
// The only serial dependency is the register file, written as each operation leaves
// the input register, so the next operation reads the updated registers.
// Reset: synchronous, active low; A, X, Y and status clear, stack pointer goes to 0xFD,
// and both the input and result registers come up empty.
`include "cpu8_register_alu_execute_unit_defines.svh"

module cpu8_register_alu_execute_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpu8_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cpu8_pkg::out_item_t out_item
);

  logic                s1_vld_r;
  logic                s1_vld_nxt;
  cpu8_pkg::in_item_t  s1_item_r;
  logic                out_vld_r;
  logic                out_vld_nxt;
  cpu8_pkg::out_item_t out_item_r;
  logic                in_xfer;
  logic                move;
  cpu8_pkg::arch_t     arch_cur;
  cpu8_pkg::arch_t     arch_new;
  cpu8_pkg::out_item_t exec_res;
  cpu8_pkg::arch_upd_t upd;

  // The operation in the input register executes once the result register is free.
  assign move        = s1_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall    = ~rst_n | (s1_vld_r & ~move);
  assign in_xfer     = in_valid & ~in_stall;
  assign s1_vld_nxt  = in_xfer | (s1_vld_r & ~move);
  assign out_vld_nxt = move | (out_vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (move) begin
      out_item_r <= exec_res;
    end
  end

  cpu8_exec u_exec (
    .item   (s1_item_r),
    .cur    (arch_cur),
    .nxt    (arch_new),
    .result (exec_res)
  );

  assign upd = '{commit: move, arch: arch_new};

  cpu8_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .arch  (arch_cur)
  );

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  `CPU8_ASSERT_CLK(a_result_matches_regs, clk, rst_n, move |=> (out_item_r.accumulator_out == arch_cur.a && out_item_r.index_x_out == arch_cur.x && out_item_r.index_y_out == arch_cur.y), "result registers disagree with register file")
  `CPU8_ASSERT_CLK(a_push_slot, clk, rst_n, (move && exec_res.push_enable) |=> (out_item_r.stack_address[7:0] == arch_cur.sp + 8'd1), "push address does not sit above the new stack pointer")
  `CPU8_ASSERT_CLK(a_one_strobe, clk, rst_n, out_vld_r |-> !(out_item_r.write_enable && out_item_r.push_enable), "store and push strobes both set")
  `CPU8_ASSERT_CLK(a_held_item, clk, rst_n, (s1_vld_r && !move) |=> (s1_vld_r && $stable(s1_item_r)), "waiting operation lost or changed")
  `CPU8_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!s1_vld_r && !out_vld_r), "input or result register not empty after reset")

endmodule

// ----- tb/sv/cpu8_exec_checker.sv -----
// Result checker for the 8-bit execute unit: a register-level predictor and a
// queue of expected results that each result transfer is compared against.
// Depends on cpu8_pkg for the item types, operation codes and flag positions.
module cpu8_exec_checker
  import cpu8_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_results
);

  arch_t     regs;
  out_item_t expected_q[$];

  function automatic void update_nz(input logic [7:0] v);
    regs.p[FLAG_Z] = (v == 8'h00);
    regs.p[FLAG_N] = v[7];
  endfunction

  // Binary add with carry; subtraction comes in with the operand inverted.
  function automatic void add_to_acc(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, regs.a} + {1'b0, m} + {8'h00, regs.p[FLAG_C]};
    regs.p[FLAG_C] = sum[8];
    regs.p[FLAG_V] = ~(regs.a[7] ^ m[7]) & (regs.a[7] ^ sum[7]);
    regs.a = sum[7:0];
    update_nz(regs.a);
  endfunction

  function automatic void compare_with(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    regs.p[FLAG_C] = (r >= m);
    regs.p[FLAG_Z] = (r == m);
    regs.p[FLAG_N] = diff[7];
  endfunction

  function automatic out_item_t execute_op(input in_item_t op);
    out_item_t  r;
    logic [7:0] m;
    logic [7:0] src;
    logic [7:0] res;
    logic       carry_in;
    r = '0;
    m = op.operand;
    carry_in = regs.p[FLAG_C];
    case (op.command)
      CMD_ADC: add_to_acc(m);
      CMD_SBC: add_to_acc(~m);
      CMD_AND: begin
        regs.a = regs.a & m;
        update_nz(regs.a);
      end
      CMD_EOR: begin
        regs.a = regs.a ^ m;
        update_nz(regs.a);
      end
      CMD_ORA: begin
        regs.a = regs.a | m;
        update_nz(regs.a);
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        src = op.on_accumulator ? regs.a : m;
        case (op.command)
          CMD_ASL: res = {src[6:0], 1'b0};
          CMD_LSR: res = {1'b0, src[7:1]};
          CMD_ROL: res = {src[6:0], carry_in};
          default: res = {carry_in, src[7:1]};
        endcase
        regs.p[FLAG_C] = (op.command == CMD_ASL || op.command == CMD_ROL) ? src[7] : src[0];
        update_nz(res);
        if (op.on_accumulator) begin
          regs.a = res;
        end else begin
          r.write_data = res;
          r.write_enable = 1'b1;
        end
      end
      CMD_BCC: r.branch_taken = ~regs.p[FLAG_C];
      CMD_BCS: r.branch_taken = regs.p[FLAG_C];
      CMD_BEQ: r.branch_taken = regs.p[FLAG_Z];
      CMD_BMI: r.branch_taken = regs.p[FLAG_N];
      CMD_BNE: r.branch_taken = ~regs.p[FLAG_Z];
      CMD_BPL: r.branch_taken = ~regs.p[FLAG_N];
      CMD_BVC: r.branch_taken = ~regs.p[FLAG_V];
      CMD_BVS: r.branch_taken = regs.p[FLAG_V];
      CMD_BIT: begin
        regs.p[FLAG_Z] = ((regs.a & m) == 8'h00);
        regs.p[FLAG_V] = m[6];
        regs.p[FLAG_N] = m[7];
      end
      // The pushed status always carries bits four and five set.
      CMD_BRK, CMD_PHA, CMD_PHP: begin
        r.write_data = (op.command == CMD_PHA) ? regs.a : (regs.p | PUSH_BITS);
        r.push_enable = 1'b1;
        r.stack_address = {1'b1, regs.sp};
        regs.sp = regs.sp - 8'd1;
        if (op.command == CMD_BRK) begin
          regs.p[FLAG_I] = 1'b1;
        end
      end
      CMD_PLA: begin
        regs.sp = regs.sp + 8'd1;
        regs.a = m;
        update_nz(regs.a);
      end
      CMD_PLP: begin
        regs.sp = regs.sp + 8'd1;
        regs.p = m & ~PUSH_BITS;
      end
      CMD_CLC: regs.p[FLAG_C] = 1'b0;
      CMD_CLD: regs.p[FLAG_D] = 1'b0;
      CMD_CLI: regs.p[FLAG_I] = 1'b0;
      CMD_CLV: regs.p[FLAG_V] = 1'b0;
      CMD_SEC: regs.p[FLAG_C] = 1'b1;
      CMD_SED: regs.p[FLAG_D] = 1'b1;
      CMD_SEI: regs.p[FLAG_I] = 1'b1;
      CMD_CMP: compare_with(regs.a, m);
      CMD_CPX: compare_with(regs.x, m);
      CMD_CPY: compare_with(regs.y, m);
      CMD_DEC, CMD_INC: begin
        res = (op.command == CMD_DEC) ? m - 8'd1 : m + 8'd1;
        update_nz(res);
        r.write_data = res;
        r.write_enable = 1'b1;
      end
      CMD_DEX: begin
        regs.x = regs.x - 8'd1;
        update_nz(regs.x);
      end
      CMD_DEY: begin
        regs.y = regs.y - 8'd1;
        update_nz(regs.y);
      end
      CMD_INX: begin
        regs.x = regs.x + 8'd1;
        update_nz(regs.x);
      end
      CMD_INY: begin
        regs.y = regs.y + 8'd1;
        update_nz(regs.y);
      end
      CMD_LDA: begin
        regs.a = m;
        update_nz(regs.a);
      end
      CMD_LDX: begin
        regs.x = m;
        update_nz(regs.x);
      end
      CMD_LDY: begin
        regs.y = m;
        update_nz(regs.y);
      end
      CMD_STA: begin
        r.write_data = regs.a;
        r.write_enable = 1'b1;
      end
      CMD_STX: begin
        r.write_data = regs.x;
        r.write_enable = 1'b1;
      end
      CMD_STY: begin
        r.write_data = regs.y;
        r.write_enable = 1'b1;
      end
      CMD_TAX: begin
        regs.x = regs.a;
        update_nz(regs.x);
      end
      CMD_TAY: begin
        regs.y = regs.a;
        update_nz(regs.y);
      end
      CMD_TSX: begin
        regs.x = regs.sp;
        update_nz(regs.x);
      end
      CMD_TXA: begin
        regs.a = regs.x;
        update_nz(regs.a);
      end
      CMD_TXS: regs.sp = regs.x;
      CMD_TYA: begin
        regs.a = regs.y;
        update_nz(regs.a);
      end
      default: ;
    endcase
    // Without a push the address shows the stack pointer after the step.
    if (!r.push_enable) begin
      r.stack_address = {1'b1, regs.sp};
    end
    r.status_out = regs.p | ONE_BIT;
    r.accumulator_out = regs.a;
    r.index_x_out = regs.x;
    r.index_y_out = regs.y;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [8:0] want_v,
                                      input logic [8:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs = '{a: 8'h00, x: 8'h00, y: 8'h00, p: 8'h00, sp: SP_RESET};
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no result expected: %h", out_item);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("write_data", 9'(want.write_data), 9'(out_item.write_data));
          check_field("write_enable", 9'(want.write_enable), 9'(out_item.write_enable));
          check_field("push_enable", 9'(want.push_enable), 9'(out_item.push_enable));
          check_field("stack_address", want.stack_address, out_item.stack_address);
          check_field("branch_taken", 9'(want.branch_taken), 9'(out_item.branch_taken));
          check_field("status_out", 9'(want.status_out), 9'(out_item.status_out));
          check_field("accumulator_out", 9'(want.accumulator_out),
                      9'(out_item.accumulator_out));
          check_field("index_x_out", 9'(want.index_x_out), 9'(out_item.index_x_out));
          check_field("index_y_out", 9'(want.index_y_out), 9'(out_item.index_y_out));
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(execute_op(in_item));
      end
    end
    pending_results = expected_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top level of the execute unit testbench: clock, reset, operation stimulus,
// random stalls on both channels, watchdog and final verdict.
// Depends on cpu8_pkg, cpu8_register_alu_execute_unit and cpu8_exec_checker.
module tb_top;
  import cpu8_pkg::*;

  // Operation numbers the package leaves unnamed.
  localparam logic [5:0] OP_JMP         = 6'd27;
  localparam logic [5:0] OP_JSR         = 6'd28;
  localparam logic [5:0] OP_NOP         = 6'd33;
  localparam logic [5:0] OP_RTI         = 6'd41;
  localparam logic [5:0] OP_RTS         = 6'd42;
  localparam logic [5:0] OP_UNUSED_LAST = 6'd63;

  localparam int RANDOM_ITEMS = 1425;
  localparam int QUIET_LIMIT  = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending_results;
  logic      in_taken = 1'b0;
  logic      idle_enable = 1'b0;
  int        quiet_cycles = 0;
  int        stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpu8_register_alu_execute_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  cpu8_exec_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side stalls in random bursts while idles are enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic [5:0] cmd, input logic [7:0] opnd, input logic on_acc);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{command: cmd, operand: opnd, on_accumulator: on_acc};
    do @(negedge clk); while (!in_taken);
  endtask

  initial begin
    int         sent;
    int         window;
    logic [5:0] cmd;
    logic [7:0] opnd;
    sent = 0;
    window = -1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    idle_enable <= 1'b1;

    // Flag extremes, decimal flag ignored by the adder, pushed status bits,
    // stack pointer wrap in both directions, and operations that change nothing.
    send_op(CMD_LDA, 8'h00, 1'b0);
    send_op(CMD_LDA, 8'h80, 1'b0);
    send_op(CMD_ADC, 8'h80, 1'b0);
    send_op(CMD_ADC, 8'h7F, 1'b1);
    send_op(CMD_SED, 8'hFF, 1'b0);
    send_op(CMD_SBC, 8'h01, 1'b1);
    send_op(CMD_CLD, 8'h00, 1'b0);
    send_op(CMD_PHP, 8'h00, 1'b0);
    send_op(CMD_PLP, 8'hFF, 1'b0);
    send_op(CMD_BRK, 8'h00, 1'b0);
    send_op(CMD_LDX, 8'h00, 1'b0);
    send_op(CMD_TXS, 8'h00, 1'b0);
    send_op(CMD_PHA, 8'h00, 1'b0);
    send_op(CMD_PLA, 8'hFF, 1'b0);
    send_op(CMD_TSX, 8'h00, 1'b0);
    send_op(CMD_ASL, 8'h00, 1'b1);
    send_op(CMD_ROR, 8'h01, 1'b0);
    send_op(CMD_ROL, 8'h80, 1'b0);
    send_op(CMD_LSR, 8'hFF, 1'b1);
    send_op(CMD_CMP, 8'hFF, 1'b0);
    send_op(CMD_BIT, 8'hC0, 1'b0);
    send_op(CMD_INC, 8'hFF, 1'b0);
    send_op(CMD_DEC, 8'h00, 1'b0);
    send_op(CMD_BVS, 8'h00, 1'b0);
    send_op(OP_NOP, 8'hFF, 1'b1);
    send_op(OP_JMP, 8'h00, 1'b0);
    send_op(OP_JSR, 8'hFF, 1'b0);
    send_op(OP_RTI, 8'h00, 1'b1);
    send_op(OP_RTS, 8'h80, 1'b0);
    send_op(OP_UNUSED_LAST, 8'h55, 1'b1);

    while (sent < RANDOM_ITEMS) begin
      if (sent / 100 != window) begin
        window = sent / 100;
        idle_enable <= (sent < RANDOM_ITEMS - 200) && ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 7))
        0: opnd = 8'h00;
        1: opnd = 8'hFF;
        2: opnd = 8'h7F;
        3: opnd = 8'h80;
        4: opnd = 8'h01;
        default: opnd = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0: begin
          // Balanced push and pull group with random pulled bytes.
          send_op(CMD_PHA, opnd, 1'b0);
          send_op(CMD_PHP, 8'($urandom_range(0, 255)), 1'b1);
          send_op(CMD_PLP, 8'($urandom_range(0, 255)), 1'b0);
          send_op(CMD_PLA, opnd, 1'b1);
          sent += 4;
        end
        1: begin
          // Set up the carry, then add or subtract.
          send_op($urandom_range(0, 1) ? CMD_SEC : CMD_CLC, 8'($urandom_range(0, 255)),
                  1'b0);
          send_op($urandom_range(0, 1) ? CMD_ADC : CMD_SBC, opnd, 1'($urandom_range(0, 1)));
          sent += 2;
        end
        default: begin
          cmd = 6'($urandom_range(0, 63));
          send_op(cmd, opnd, 1'($urandom_range(0, 1)));
          sent += 1;
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cpu8_pkg.sv
rtl/cpu8_exec.sv
rtl/cpu8_state.sv
rtl/cpu8_register_alu_execute_unit.sv
tb/sv/cpu8_exec_checker.sv
tb/sv/tb_top.sv
